[rtl/rsr_pkg.sv]
// shared types and constants for the rs485 slave command responder
`timescale 1ns / 1ps
`default_nettype none

package rsr_pkg;

  localparam logic [7:0] SYNC0 = 8'hAA;
  localparam logic [7:0] SYNC1 = 8'h00;
  localparam logic [7:0] SYNC2 = 8'hFF;
  localparam int unsigned STATUS_LEN = 23;
  localparam int unsigned IDX_W = $clog2(STATUS_LEN);
  localparam int unsigned JOBQ_DEPTH = 2;
  localparam int unsigned JOBQ_PTR_W = $clog2(JOBQ_DEPTH);

  localparam logic [3:0] CMD_STATUS = 4'd0;
  localparam logic [3:0] CMD_SPEED = 4'd1;

  localparam logic [0:0] REG_OWN_ADDRESS = 1'b0;
  localparam logic [0:0] REG_REPLY_ID = 1'b1;

  typedef enum logic [1:0] {
    KIND_TX = 2'd0,
    KIND_SPEED = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic signed [31:0] air_temp;
    logic [31:0] air_pressure;
    logic [31:0] air_humidity;
    logic signed [15:0] motor_temp;
    logic [7:0] rpm_now;
    logic [7:0] rpm_average;
    logic [7:0] speed_setpoint;
    logic spin_fault;
    logic overheat_fault;
  } in_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] tx_data;
    logic tx_last;
    logic [7:0] speed_value;
  } out_word_t;

  // work handed from the parser to the reply side
  typedef struct packed {
    kind_e kind;
    logic [7:0] speed_value;
    logic signed [31:0] air_temp;
    logic [31:0] air_pressure;
    logic [31:0] air_humidity;
    logic signed [15:0] motor_temp;
    logic [7:0] rpm_now;
    logic [7:0] rpm_average;
    logic [7:0] speed_setpoint;
    logic spin_fault;
    logic overheat_fault;
  } job_t;

endpackage

`default_nettype wire

[rtl/rs485_slave_command_responder.sv]
// top level of the rs485 slave command responder
`timescale 1ns / 1ps
`default_nettype none

// Takes one received bus byte per cycle (push while full is low) and parses
// frames AA 00 FF, address/command, data. A frame for this address becomes a
// job in a two-entry queue; the reply side turns a status job into 23 result
// words, one per cycle while pop keeps taking them, and a speed or
// unknown-command job into one word. Results wait in a one-word output
// register and are taken with pop while empty is low. The byte input stalls
// only when the job queue is full, so the parser keeps taking bytes while a
// status reply goes out through the single output register. Configuration
// writes take effect at once and are meant for when the block is idle.
module rs485_slave_command_responder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire rsr_pkg::in_word_t  in_word_i,
  input  wire logic               pop,
  output logic                    empty,
  output rsr_pkg::out_word_t      out_word_o,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i
);

  logic [3:0] own_address_q;
  logic [7:0] reply_id_q;
  logic accept;
  logic job_push, job_pop, job_valid, jobq_full;
  rsr_pkg::job_t job_in, job_head;

  assign full = jobq_full;
  assign accept = push && !jobq_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= 4'd10;
      reply_id_q <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsr_pkg::REG_OWN_ADDRESS: own_address_q <= cfg_data_i[3:0];
        rsr_pkg::REG_REPLY_ID: reply_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rsr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_word_i     (in_word_i),
    .own_address_i (own_address_q),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  rsr_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (jobq_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (job_head)
  );

  rsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .reply_id_i  (reply_id_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

[rtl/rsr_front.sv]
// frame parser: sync hunt, address and command decode, job issue
`timescale 1ns / 1ps
`default_nettype none

module rsr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire rsr_pkg::in_word_t in_word_i,
  input  wire logic [3:0]        own_address_i,
  output logic                   job_push_o,
  output rsr_pkg::job_t          job_o
);

  typedef enum logic [4:0] {
    ST_HUNT = 5'b00001,
    ST_SYNC1 = 5'b00010,
    ST_SYNC2 = 5'b00100,
    ST_ADDR = 5'b01000,
    ST_DATA = 5'b10000
  } phase_e;

  phase_e phase_q, phase_d;
  logic [3:0] cmd_q, cmd_d;
  logic [3:0] addr_q, addr_d;
  logic [7:0] c;

  assign c = in_word_i.rx_byte;

  always_comb begin
    phase_d = phase_q;
    cmd_d = cmd_q;
    addr_d = addr_q;
    if (accept_i) begin
      case (phase_q)
        ST_HUNT: begin
          if (c == rsr_pkg::SYNC0) phase_d = ST_SYNC1;
        end
        ST_SYNC1: phase_d = (c == rsr_pkg::SYNC1) ? ST_SYNC2 : ST_HUNT;
        ST_SYNC2: phase_d = (c == rsr_pkg::SYNC2) ? ST_ADDR : ST_HUNT;
        ST_ADDR: begin
          cmd_d = c[3:0];
          addr_d = c[7:4];
          phase_d = ST_DATA;
        end
        default: phase_d = ST_HUNT;
      endcase
    end
  end

  assign job_push_o = accept_i && (phase_q == ST_DATA) && (addr_q == own_address_i);

  always_comb begin
    job_o.kind = rsr_pkg::KIND_UNKNOWN;
    job_o.speed_value = {4'd0, cmd_q};
    if (cmd_q == rsr_pkg::CMD_STATUS) begin
      job_o.kind = rsr_pkg::KIND_TX;
      job_o.speed_value = 8'd0;
    end else if (cmd_q == rsr_pkg::CMD_SPEED) begin
      job_o.kind = rsr_pkg::KIND_SPEED;
      job_o.speed_value = c;
    end
    job_o.air_temp = in_word_i.air_temp;
    job_o.air_pressure = in_word_i.air_pressure;
    job_o.air_humidity = in_word_i.air_humidity;
    job_o.motor_temp = in_word_i.motor_temp;
    job_o.rpm_now = in_word_i.rpm_now;
    job_o.rpm_average = in_word_i.rpm_average;
    job_o.speed_setpoint = in_word_i.speed_setpoint;
    job_o.spin_fault = in_word_i.spin_fault;
    job_o.overheat_fault = in_word_i.overheat_fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ST_HUNT;
      cmd_q <= 4'hF;
      addr_q <= 4'hF;
    end else begin
      phase_q <= phase_d;
      cmd_q <= cmd_d;
      addr_q <= addr_d;
    end
  end

endmodule

`default_nettype wire

[rtl/rsr_jobq.sv]
// short job queue between the parser and the reply side
`timescale 1ns / 1ps
`default_nettype none

module rsr_jobq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rsr_pkg::job_t job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output rsr_pkg::job_t      job_o
);

  localparam int unsigned CNT_W = $clog2(rsr_pkg::JOBQ_DEPTH + 1);

  rsr_pkg::job_t mem_q [rsr_pkg::JOBQ_DEPTH];
  logic [rsr_pkg::JOBQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic do_push, do_pop;

  assign full_o = (count_q == CNT_W'(rsr_pkg::JOBQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == rsr_pkg::JOBQ_PTR_W'(rsr_pkg::JOBQ_DEPTH - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == rsr_pkg::JOBQ_PTR_W'(rsr_pkg::JOBQ_DEPTH - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/rsr_back.sv]
// reply side: walks status bytes out and holds the result word register
`timescale 1ns / 1ps
`default_nettype none

module rsr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire rsr_pkg::job_t job_i,
  output logic               job_pop_o,
  input  wire logic [7:0]    reply_id_i,
  input  wire logic          pop_i,
  output logic               empty_o,
  output rsr_pkg::out_word_t out_word_o
);

  localparam int unsigned IDX_W = rsr_pkg::IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(rsr_pkg::STATUS_LEN - 1);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  rsr_pkg::out_word_t out_q, out_d;
  logic load;
  logic [rsr_pkg::STATUS_LEN-1:0][7:0] status;

  // byte 0 sits in the lowest slot
  always_comb begin
    status[0] = rsr_pkg::SYNC0;
    status[1] = rsr_pkg::SYNC1;
    status[2] = rsr_pkg::SYNC2;
    status[3] = reply_id_i;
    status[4] = job_i.air_temp[7:0];
    status[5] = job_i.air_temp[15:8];
    status[6] = job_i.air_temp[23:16];
    status[7] = job_i.air_temp[31:24];
    status[8] = job_i.air_pressure[7:0];
    status[9] = job_i.air_pressure[15:8];
    status[10] = job_i.air_pressure[23:16];
    status[11] = job_i.air_pressure[31:24];
    status[12] = job_i.air_humidity[7:0];
    status[13] = job_i.air_humidity[15:8];
    status[14] = job_i.air_humidity[23:16];
    status[15] = job_i.air_humidity[31:24];
    status[16] = job_i.motor_temp[7:0];
    status[17] = job_i.motor_temp[15:8];
    status[18] = job_i.rpm_now;
    status[19] = job_i.rpm_average;
    status[20] = job_i.speed_setpoint;
    status[21] = {7'd0, job_i.spin_fault};
    status[22] = {7'd0, job_i.overheat_fault};
  end

  assign load = !out_valid_q || pop_i;

  always_comb begin
    idx_d = idx_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !pop_i;
    job_pop_o = 1'b0;
    if (load && job_valid_i) begin
      out_valid_d = 1'b1;
      out_d.result_kind = job_i.kind;
      out_d.speed_value = job_i.speed_value;
      out_d.tx_data = 8'd0;
      out_d.tx_last = 1'b0;
      if (job_i.kind == rsr_pkg::KIND_TX) begin
        out_d.tx_data = status[idx_q];
        out_d.tx_last = (idx_q == LAST_IDX);
        if (idx_q == LAST_IDX) begin
          idx_d = '0;
          job_pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end else begin
        job_pop_o = 1'b1;
      end
    end
  end

  assign empty_o = !out_valid_q;
  assign out_word_o = out_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire
